/* rtl/lsag_pkg.sv */
// Package: shared types, codes and constants of the light sensor auto gain block.
`timescale 1ns / 1ps

package lsag_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_MEAS_DONE = 2'd1,
    ACT_SET_DONE = 2'd2
  } action_e;

  // Commands issued on the result channel
  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_SET     = 2'd1,
    CMD_DONE    = 2'd2
  } command_e;

  // Outcome of a finished run
  typedef enum logic [1:0] {
    OUT_KEPT    = 2'd0,
    OUT_CHANGED = 2'd1,
    OUT_ERROR   = 2'd2
  } outcome_e;

  // Locked adjustment direction
  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_HIGHER = 2'd1,
    DIR_LOWER  = 2'd2
  } dir_e;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MEAS = 2'd1,
    PH_SET  = 2'd2
  } phase_e;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HIGH_THR    = 2'd0;
  localparam logic [1:0] REG_LOW_THR     = 2'd1;
  localparam logic [1:0] REG_MAX_CHANGES = 2'd2;

  // Register reset values
  localparam logic [15:0] HIGH_THR_RST    = 16'd50000;
  localparam logic [15:0] LOW_THR_RST     = 16'd7500;
  localparam logic [6:0]  MAX_CHANGES_RST = 7'd16;

  // Sample code for an overexposed measurement
  localparam logic [15:0] OVEREXPOSED = 16'hFFFF;

  // Gain index limits and range switch points
  localparam logic [2:0] GAIN_MIN        = 3'd0;
  localparam logic [2:0] GAIN_NORMAL_MAX = 3'd7;
  localparam logic [2:0] GAIN_HIGH_LIMIT = 3'd5;
  localparam logic [2:0] GAIN_TO_NORMAL  = 3'd1;
  localparam logic [2:0] GAIN_TO_HIGH    = 3'd3;

  localparam logic RANGE_NORMAL = 1'b0;
  localparam logic RANGE_HIGH   = 1'b1;

  typedef struct packed {
    logic [15:0] high_thr;
    logic [15:0] low_thr;
    logic [6:0]  max_changes;
  } cfg_t;

  typedef struct packed {
    logic       cur_range;
    logic [2:0] cur_gain;
    dir_e       direction;
    logic [6:0] change_count;
    logic       changed_flag;
    logic       after_change;
    logic       rejecting;
    phase_e     phase;
  } state_t;

  typedef struct packed {
    command_e   command;
    logic       range_out;
    logic [2:0] gain_out;
    outcome_e   outcome;
  } result_t;

endpackage

/* rtl/lsag_regs.sv */
// APB-style configuration registers: thresholds and change limit.
`timescale 1ns / 1ps

module lsag_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lsag_pkg::cfg_t    cfg_o
);

  lsag_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        lsag_pkg::REG_HIGH_THR:    cfg_d.high_thr    = pwdata[15:0];
        lsag_pkg::REG_LOW_THR:     cfg_d.low_thr     = pwdata[15:0];
        lsag_pkg::REG_MAX_CHANGES: cfg_d.max_changes = pwdata[6:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr    <= lsag_pkg::HIGH_THR_RST;
      cfg_q.low_thr     <= lsag_pkg::LOW_THR_RST;
      cfg_q.max_changes <= lsag_pkg::MAX_CHANGES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      lsag_pkg::REG_HIGH_THR:    prdata = {16'd0, cfg_q.high_thr};
      lsag_pkg::REG_LOW_THR:     prdata = {16'd0, cfg_q.low_thr};
      lsag_pkg::REG_MAX_CHANGES: prdata = {25'd0, cfg_q.max_changes};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/lsag_step.sv */
// Event decode and gain/range update for one sequencer event.
`timescale 1ns / 1ps

module lsag_step (
  input  lsag_pkg::state_t  st_i,
  input  lsag_pkg::cfg_t    cfg_i,
  input  logic [1:0]        action_i,
  input  logic              start_range_i,
  input  logic [2:0]        start_gain_i,
  input  logic [15:0]       sample_i,
  input  logic              ok_i,
  output lsag_pkg::state_t  st_o,
  output lsag_pkg::result_t res_o
);

  logic       more_ok, less_ok;
  logic       more_range, less_range;
  logic [2:0] more_gain, less_gain;
  logic       want_more, want_less;
  logic       change;
  lsag_pkg::command_e cmd;
  lsag_pkg::outcome_e oc;
  lsag_pkg::outcome_e run_oc;

  // Step toward more signal: raise gain, or leave high range
  always_comb begin
    more_ok    = 1'b1;
    more_range = st_i.cur_range;
    more_gain  = st_i.cur_gain;
    if ((st_i.cur_range == lsag_pkg::RANGE_NORMAL && st_i.cur_gain < lsag_pkg::GAIN_NORMAL_MAX)
        || (st_i.cur_range == lsag_pkg::RANGE_HIGH
            && st_i.cur_gain < lsag_pkg::GAIN_HIGH_LIMIT)) begin
      more_gain = st_i.cur_gain + 3'd1;
    end else if (st_i.cur_range == lsag_pkg::RANGE_HIGH) begin
      more_range = lsag_pkg::RANGE_NORMAL;
      more_gain  = lsag_pkg::GAIN_TO_NORMAL;
    end else begin
      more_ok = 1'b0;
    end
  end

  // Step toward less signal: lower gain, or enter high range
  always_comb begin
    less_ok    = 1'b1;
    less_range = st_i.cur_range;
    less_gain  = st_i.cur_gain;
    if (st_i.cur_gain > lsag_pkg::GAIN_MIN) begin
      less_gain = st_i.cur_gain - 3'd1;
    end else if (st_i.cur_range == lsag_pkg::RANGE_NORMAL) begin
      less_range = lsag_pkg::RANGE_HIGH;
      less_gain  = lsag_pkg::GAIN_TO_HIGH;
    end else begin
      less_ok = 1'b0;
    end
  end

  assign want_more = (sample_i < cfg_i.low_thr) && (st_i.direction != lsag_pkg::DIR_LOWER);
  assign want_less = (sample_i > cfg_i.high_thr) && (st_i.direction != lsag_pkg::DIR_HIGHER);
  assign run_oc    = st_i.changed_flag ? lsag_pkg::OUT_CHANGED : lsag_pkg::OUT_KEPT;

  // Event handling
  always_comb begin
    st_o   = st_i;
    cmd    = lsag_pkg::CMD_DONE;
    oc     = lsag_pkg::OUT_ERROR;
    change = 1'b0;
    case (lsag_pkg::action_e'(action_i))
      lsag_pkg::ACT_START: begin
        if (ok_i) begin
          st_o.cur_range    = start_range_i;
          st_o.cur_gain     = start_gain_i;
          st_o.direction    = lsag_pkg::DIR_NONE;
          st_o.change_count = 7'd0;
          st_o.changed_flag = 1'b0;
          st_o.after_change = 1'b0;
          st_o.rejecting    = 1'b0;
          st_o.phase        = lsag_pkg::PH_MEAS;
          cmd               = lsag_pkg::CMD_MEASURE;
          oc                = lsag_pkg::OUT_KEPT;
        end
      end
      lsag_pkg::ACT_MEAS_DONE: begin
        if (st_i.phase == lsag_pkg::PH_MEAS && ok_i) begin
          if (st_i.after_change && st_i.direction == lsag_pkg::DIR_HIGHER
              && sample_i == lsag_pkg::OVEREXPOSED) begin
            // saturated after a step up: back it out
            st_o.cur_range = less_range;
            st_o.cur_gain  = less_gain;
            st_o.rejecting = 1'b1;
            cmd            = lsag_pkg::CMD_SET;
            oc             = lsag_pkg::OUT_KEPT;
          end else if (st_i.change_count >= cfg_i.max_changes) begin
            oc = run_oc;
          end else begin
            if (want_more) begin
              st_o.direction = lsag_pkg::DIR_HIGHER;
              change         = more_ok;
              st_o.cur_range = more_range;
              st_o.cur_gain  = more_gain;
            end else if (want_less) begin
              st_o.direction = lsag_pkg::DIR_LOWER;
              change         = less_ok;
              st_o.cur_range = less_range;
              st_o.cur_gain  = less_gain;
            end
            if (change) begin
              st_o.changed_flag = 1'b1;
              st_o.change_count = st_i.change_count + 7'd1;
              st_o.after_change = 1'b1;
              st_o.rejecting    = 1'b0;
              cmd               = lsag_pkg::CMD_SET;
              oc                = lsag_pkg::OUT_KEPT;
            end else begin
              oc = run_oc;
            end
          end
        end
      end
      lsag_pkg::ACT_SET_DONE: begin
        if (st_i.phase == lsag_pkg::PH_SET && ok_i) begin
          if (st_i.rejecting) begin
            oc = lsag_pkg::OUT_CHANGED;
          end else begin
            cmd = lsag_pkg::CMD_MEASURE;
            oc  = lsag_pkg::OUT_KEPT;
          end
        end
      end
      default: begin
        cmd = lsag_pkg::CMD_DONE;
        oc  = lsag_pkg::OUT_ERROR;
      end
    endcase
    // next phase follows from the command
    case (cmd)
      lsag_pkg::CMD_MEASURE: st_o.phase = lsag_pkg::PH_MEAS;
      lsag_pkg::CMD_SET:     st_o.phase = lsag_pkg::PH_SET;
      default:               st_o.phase = lsag_pkg::PH_IDLE;
    endcase
  end

  assign res_o.command   = cmd;
  assign res_o.range_out = st_o.cur_range;
  assign res_o.gain_out  = st_o.cur_gain;
  assign res_o.outcome   = oc;

endmodule

/* rtl/light_sensor_auto_gain_core.sv */
// Top level of the light sensor auto gain sequencer: event register, state, result register.
`timescale 1ns / 1ps

// Auto-exposure sequencer for a two-range, eight-gain light sensor. Each event
// transfer (start, measurement done, mode set done) yields exactly one command
// transfer (measure, set mode, or finished with kept/changed/error), moving from
// the event register into the result register. One event is taken per cycle while
// the output side is not stalled: the event register feeds the decode and gain/range
// update, which writes the run state and the result register in the same edge,
// so the next event already sees the updated state. The result register and the
// event register each hold one item, so while a result waits the input side takes
// one more event and then holds off until the result is taken. Thresholds and the
// change limit live on the APB port at byte addresses 0, 4 and 8 and should be
// written only while no run is in flight.

module light_sensor_auto_gain_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        start_range_i,
  input  logic [2:0]  start_gain_i,
  input  logic [15:0] sample_i,
  input  logic        ok_i,
  // command channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  command_o,
  output logic        range_out_o,
  output logic [2:0]  gain_out_o,
  output logic [1:0]  outcome_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lsag_pkg::cfg_t    cfg;
  lsag_pkg::state_t  st_q, st_d;
  lsag_pkg::result_t res_d, res_q;

  logic        in_valid_q;
  logic [1:0]  action_q;
  logic        start_range_q;
  logic [2:0]  start_gain_q;
  logic [15:0] sample_q;
  logic        ok_q;
  logic        out_valid_q;
  logic        advance;
  logic        load_out;
  logic        in_xfer;

  lsag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: output slot frees when empty or taken
  assign advance    = !out_valid_q || out_ready_i;
  assign load_out   = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q      <= action_i;
      start_range_q <= start_range_i;
      start_gain_q  <= start_gain_i;
      sample_q      <= sample_i;
      ok_q          <= ok_i;
    end
  end

  lsag_step u_step (
    .st_i          (st_q),
    .cfg_i         (cfg),
    .action_i      (action_q),
    .start_range_i (start_range_q),
    .start_gain_i  (start_gain_q),
    .sample_i      (sample_q),
    .ok_i          (ok_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  // Run state, updated as each event moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cur_range    <= 1'b0;
      st_q.cur_gain     <= 3'd0;
      st_q.direction    <= lsag_pkg::DIR_NONE;
      st_q.change_count <= 7'd0;
      st_q.changed_flag <= 1'b0;
      st_q.after_change <= 1'b0;
      st_q.rejecting    <= 1'b0;
      st_q.phase        <= lsag_pkg::PH_IDLE;
    end else if (load_out) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = res_q.command;
  assign range_out_o = res_q.range_out;
  assign gain_out_o  = res_q.gain_out;
  assign outcome_o   = res_q.outcome;

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && res_d.command == lsag_pkg::CMD_DONE |=> st_q.phase == lsag_pkg::PH_IDLE)
    else $error("sequencer not idle after finished command");

  // Only finished commands carry a nonzero outcome
  a_outcome_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o != lsag_pkg::CMD_DONE |-> outcome_o == lsag_pkg::OUT_KEPT)
    else $error("outcome set on a non-finished command");

  // Awaiting a mode set means at least one change was made
  a_set_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == lsag_pkg::PH_SET |-> st_q.change_count != 7'd0)
    else $error("mode set awaited with no change counted");

  // Undoing a step only happens on an upward run
  a_reject_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rejecting |-> st_q.direction == lsag_pkg::DIR_HIGHER)
    else $error("reject pending without upward direction");

endmodule

/* dv/tb_light_sensor_auto_gain_core.sv */
// Testbench for the light sensor auto gain sequencer: directed and random event streams.
`timescale 1ns / 1ps

module tb_light_sensor_auto_gain_core;

  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned HOLD_AFTER     = 600;
  localparam int unsigned N_SETTINGS     = 8;
  localparam int unsigned RUN_EVENTS     = 250;
  localparam int unsigned TAIL_EVENTS    = 150;

  // Tracks the sequencer state, predicts one command per event, checks commands
  class gain_scoreboard;
    logic [15:0] high_thr    = lsag_pkg::HIGH_THR_RST;
    logic [15:0] low_thr     = lsag_pkg::LOW_THR_RST;
    logic [6:0]  max_changes = lsag_pkg::MAX_CHANGES_RST;

    logic             cur_range    = lsag_pkg::RANGE_NORMAL;
    logic [2:0]       cur_gain     = lsag_pkg::GAIN_MIN;
    lsag_pkg::dir_e   direction    = lsag_pkg::DIR_NONE;
    logic [6:0]       change_count = '0;
    logic             changed_flag = 1'b0;
    logic             after_change = 1'b0;
    logic             rejecting    = 1'b0;
    lsag_pkg::phase_e phase        = lsag_pkg::PH_IDLE;

    lsag_pkg::result_t expected_cmds[$];
    int unsigned mismatches = 0;
    int unsigned checked    = 0;
    int unsigned runs       = 0;
    int unsigned steps      = 0;
    int unsigned reverts    = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        lsag_pkg::REG_HIGH_THR:    high_thr = value[15:0];
        lsag_pkg::REG_LOW_THR:     low_thr = value[15:0];
        lsag_pkg::REG_MAX_CHANGES: max_changes = value[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_cmds.size();
    endfunction

    function void push_cmd(lsag_pkg::command_e cmd, lsag_pkg::outcome_e oc);
      lsag_pkg::result_t r;
      r.command   = cmd;
      r.range_out = cur_range;
      r.gain_out  = cur_gain;
      r.outcome   = oc;
      expected_cmds.push_back(r);
    endfunction

    function void finish_run(lsag_pkg::outcome_e oc);
      phase = lsag_pkg::PH_IDLE;
      push_cmd(lsag_pkg::CMD_DONE, oc);
    endfunction

    function lsag_pkg::outcome_e run_outcome();
      if (changed_flag) return lsag_pkg::OUT_CHANGED;
      return lsag_pkg::OUT_KEPT;
    endfunction

    // Step toward more signal; high range tops out early and drops to normal
    function bit raise_signal();
      if ((cur_range == lsag_pkg::RANGE_NORMAL && cur_gain < lsag_pkg::GAIN_NORMAL_MAX) ||
          (cur_range == lsag_pkg::RANGE_HIGH && cur_gain < lsag_pkg::GAIN_HIGH_LIMIT)) begin
        cur_gain = cur_gain + 3'd1;
        return 1'b1;
      end
      if (cur_range == lsag_pkg::RANGE_HIGH) begin
        cur_range = lsag_pkg::RANGE_NORMAL;
        cur_gain  = lsag_pkg::GAIN_TO_NORMAL;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Step toward less signal; at gain 0 in normal range go to high range
    function bit drop_signal();
      if (cur_gain > lsag_pkg::GAIN_MIN) begin
        cur_gain = cur_gain - 3'd1;
        return 1'b1;
      end
      if (cur_range == lsag_pkg::RANGE_NORMAL) begin
        cur_range = lsag_pkg::RANGE_HIGH;
        cur_gain  = lsag_pkg::GAIN_TO_HIGH;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_event(logic [1:0] act, logic rng, logic [2:0] gain,
                             logic [15:0] sample, logic ok);
      bit moved;
      moved = 1'b0;
      if (act == lsag_pkg::ACT_START) begin
        if (!ok) begin
          finish_run(lsag_pkg::OUT_ERROR);
          return;
        end
        runs++;
        cur_range    = rng;
        cur_gain     = gain;
        direction    = lsag_pkg::DIR_NONE;
        change_count = '0;
        changed_flag = 1'b0;
        after_change = 1'b0;
        rejecting    = 1'b0;
        phase        = lsag_pkg::PH_MEAS;
        push_cmd(lsag_pkg::CMD_MEASURE, lsag_pkg::OUT_KEPT);
        return;
      end
      if (act == lsag_pkg::ACT_MEAS_DONE && phase == lsag_pkg::PH_MEAS) begin
        if (!ok) begin
          finish_run(lsag_pkg::OUT_ERROR);
          return;
        end
        // overexposure right after a step up takes the step back
        if (after_change && direction == lsag_pkg::DIR_HIGHER &&
            sample == lsag_pkg::OVEREXPOSED) begin
          void'(drop_signal());
          reverts++;
          rejecting = 1'b1;
          phase     = lsag_pkg::PH_SET;
          push_cmd(lsag_pkg::CMD_SET, lsag_pkg::OUT_KEPT);
          return;
        end
        if (change_count >= max_changes) begin
          finish_run(run_outcome());
          return;
        end
        // more signal wins when both thresholds match
        if (sample < low_thr && direction != lsag_pkg::DIR_LOWER) begin
          direction = lsag_pkg::DIR_HIGHER;
          moved = raise_signal();
        end else if (sample > high_thr && direction != lsag_pkg::DIR_HIGHER) begin
          direction = lsag_pkg::DIR_LOWER;
          moved = drop_signal();
        end
        if (!moved) begin
          finish_run(run_outcome());
          return;
        end
        steps++;
        changed_flag = 1'b1;
        change_count = change_count + 7'd1;
        after_change = 1'b1;
        rejecting    = 1'b0;
        phase        = lsag_pkg::PH_SET;
        push_cmd(lsag_pkg::CMD_SET, lsag_pkg::OUT_KEPT);
        return;
      end
      if (act == lsag_pkg::ACT_SET_DONE && phase == lsag_pkg::PH_SET) begin
        if (!ok) begin
          finish_run(lsag_pkg::OUT_ERROR);
        end else if (rejecting) begin
          finish_run(lsag_pkg::OUT_CHANGED);
        end else begin
          phase = lsag_pkg::PH_MEAS;
          push_cmd(lsag_pkg::CMD_MEASURE, lsag_pkg::OUT_KEPT);
        end
        return;
      end
      // idle, unexpected event or unused action code
      finish_run(lsag_pkg::OUT_ERROR);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_command(lsag_pkg::result_t got);
      lsag_pkg::result_t want;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("command %0d with nothing expected", got.command));
        return;
      end
      want = expected_cmds.pop_front();
      checked++;
      if (got.command !== want.command)
        report_mismatch($sformatf("command %0d, expected %0d", got.command, want.command));
      if (got.range_out !== want.range_out)
        report_mismatch($sformatf("range %0d, expected %0d", got.range_out, want.range_out));
      if (got.gain_out !== want.gain_out)
        report_mismatch($sformatf("gain %0d, expected %0d", got.gain_out, want.gain_out));
      if (got.outcome !== want.outcome)
        report_mismatch($sformatf("outcome %0d, expected %0d", got.outcome, want.outcome));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = '0;
  logic        start_range_i = 1'b0;
  logic [2:0]  start_gain_i  = '0;
  logic [15:0] sample_i      = '0;
  logic        ok_i          = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  command_o;
  logic        range_out_o;
  logic [2:0]  gain_out_o;
  logic [1:0]  outcome_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  gain_scoreboard    board = new();
  lsag_pkg::result_t seen;
  int unsigned events_sent = 0;
  int unsigned cycles = 0;
  bit          quiet_tail = 1'b0;

  // threshold and change limit settings, one per random phase for the first six phases
  int unsigned high_set [6] = '{50000, 65535, 0, 40000, 30000, 20000};
  int unsigned low_set  [6] = '{7500, 0, 65535, 20000, 1000, 20000};
  int unsigned max_set  [6] = '{16, 1, 127, 0, 64, 2};

  light_sensor_auto_gain_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .start_range_i (start_range_i),
    .start_gain_i  (start_gain_i),
    .sample_i      (sample_i),
    .ok_i          (ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .command_o     (command_o),
    .range_out_o   (range_out_o),
    .gain_out_o    (gain_out_o),
    .outcome_o     (outcome_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d commands outstanding", cycles, board.pending());
    $display("tb_light_sensor_auto_gain_core NOT OK");
    $finish;
  end

  // Command side: check every transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.command   = lsag_pkg::command_e'(command_o);
      seen.range_out = range_out_o;
      seen.gain_out  = gain_out_o;
      seen.outcome   = lsag_pkg::outcome_e'(outcome_o);
      board.check_command(seen);
    end
  end

  // Command side backpressure: short stalls, calm stretches, one long hold
  initial begin : ready_ctrl
    bit held;
    held = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && events_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if ($urandom_range(3) == 0) repeat ($urandom_range(60, 20)) @(posedge clk_i);
      else repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  end

  // One event transfer; the prediction is taken at the accepting edge
  task automatic send_event(input logic [1:0] act, input logic rng, input logic [2:0] gain,
                            input logic [15:0] sample, input logic ok);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    start_range_i <= rng;
    start_gain_i  <= gain;
    sample_i      <= sample;
    ok_i          <= ok;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_event(act, rng, gain, sample, ok);
    events_sent++;
  endtask

  // Samples biased toward each threshold region and overexposure
  function automatic logic [15:0] pick_sample(logic [15:0] lo, logic [15:0] hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30 && lo != 16'd0) return 16'($urandom_range(lo - 1, 0));
    if (roll < 60 && hi != 16'hFFFF) return 16'($urandom_range(65535, hi + 1));
    if (roll < 70) return lsag_pkg::OVEREXPOSED;
    if (roll < 90 && lo <= hi) return 16'($urandom_range(hi, lo));
    return 16'($urandom_range(65535));
  endfunction

  // Mostly the event the sequencer waits for, some stray or failed ones
  task automatic send_random_event();
    logic [1:0] act;
    logic       ok;
    if (!quiet_tail && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    if ($urandom_range(99) < 4) begin
      act = 2'($urandom_range(3));
    end else begin
      case (board.phase)
        lsag_pkg::PH_IDLE: act = lsag_pkg::ACT_START;
        lsag_pkg::PH_MEAS: act = lsag_pkg::ACT_MEAS_DONE;
        default:           act = lsag_pkg::ACT_SET_DONE;
      endcase
    end
    ok = ($urandom_range(99) >= 3);
    send_event(act, 1'($urandom_range(1)), 3'($urandom_range(7)),
               pick_sample(board.low_thr, board.high_thr), ok);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Drain: every command in, plus the pipeline depth
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    int unsigned hi_v;
    int unsigned lo_v;
    int unsigned mx_v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed events with reset thresholds
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd0, 1'b1);      // measurement while idle
    send_event(lsag_pkg::ACT_START, 1'b1, 3'd7, 16'hFFFF, 1'b0);       // failed start
    send_event(lsag_pkg::ACT_START, 1'b1, 3'd7, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd0, 1'b1);      // high top -> normal
    send_event(lsag_pkg::ACT_SET_DONE, 1'b0, 3'd0, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b1, 3'd7, lsag_pkg::OVEREXPOSED, 1'b1); // revert
    send_event(lsag_pkg::ACT_SET_DONE, 1'b1, 3'd7, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_START, 1'b0, 3'd0, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd65535, 1'b1);  // normal 0 -> high
    send_event(lsag_pkg::ACT_SET_DONE, 1'b0, 3'd0, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, lsag_pkg::OVEREXPOSED, 1'b1); // lowering
    send_event(lsag_pkg::ACT_SET_DONE, 1'b0, 3'd0, 16'd0, 1'b0);       // failed mode set
    send_event(lsag_pkg::ACT_START, 1'b0, 3'd7, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd0, 1'b1);      // no gain left, kept
    send_event(lsag_pkg::ACT_START, 1'b1, 3'd0, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd60000, 1'b1);  // no attenuation left
    send_event(lsag_pkg::ACT_START, 1'b0, 3'd3, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd1, 1'b0);      // failed measurement
    send_event(2'd3, 1'b1, 3'd5, 16'h5555, 1'b1);                      // unused action code
    send_event(lsag_pkg::ACT_START, 1'b0, 3'd3, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_SET_DONE, 1'b0, 3'd0, 16'd0, 1'b1);       // wrong event
    send_event(lsag_pkg::ACT_START, 1'b0, 3'd3, 16'd0, 1'b1);
    send_event(lsag_pkg::ACT_MEAS_DONE, 1'b0, 3'd0, 16'd20000, 1'b1);  // in band, kept
    settle();

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < N_SETTINGS; p++) begin
      if (p < 6) begin
        hi_v = high_set[p];
        lo_v = low_set[p];
        mx_v = max_set[p];
      end else begin
        hi_v = $urandom_range(65535);
        lo_v = $urandom_range(65535);
        mx_v = $urandom_range(127);
      end
      write_reg(lsag_pkg::REG_HIGH_THR, {16'($urandom), 16'(hi_v)});
      write_reg(lsag_pkg::REG_LOW_THR, {16'($urandom), 16'(lo_v)});
      write_reg(lsag_pkg::REG_MAX_CHANGES, {25'($urandom), 7'(mx_v)});
      for (int unsigned i = 0; i < RUN_EVENTS; i++) begin
        quiet_tail = (p == N_SETTINGS - 1) && (i >= RUN_EVENTS - TAIL_EVENTS);
        send_random_event();
      end
      settle();
    end

    $display("Covered %0d events and %0d commands over %0d register settings",
             events_sent, board.checked, N_SETTINGS + 1);
    $display("  %0d runs started, %0d gain or range steps, %0d overexposure reverts",
             board.runs, board.steps, board.reverts);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_light_sensor_auto_gain_core OK");
    end else begin
      $display("tb_light_sensor_auto_gain_core NOT OK");
    end
    $finish;
  end

endmodule
